// ----- hw/rtl/slmb_pkg.sv -----
// ----------------------------------------------------------------------------
// slmb_pkg
// Shared types, constants and elaboration-time helpers for the spectrum
// log-magnitude binning block.
// ----------------------------------------------------------------------------
package slmb_pkg;

   // Width of one stored magnitude.
   localparam int unsigned MAG_W = 24;
   // Fractional bits of the fixed-point log2.
   localparam int unsigned LOG_FRAC = 24;
   // round(2000 * log10(2) * 2^20).
   localparam logic signed [31:0] DB_SCALE = 32'sd631305657;
   // Level given out for a window whose mean is zero.
   localparam logic signed [14:0] ZERO_LEVEL = -15'sd15000;
   localparam logic signed [19:0] LVL_MIN = -20'sd16384;
   localparam logic signed [19:0] LVL_MAX = 20'sd16383;
   // Frame size limits and reset value.
   localparam logic [3:0] FRAME_LOG2_MIN = 4'd3;
   localparam logic [3:0] FRAME_LOG2_RESET = 4'd10;
   // Configuration port.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_IDX_FRAME_LOG2 = 1'b0;

   // Opcodes of an input beat.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [23:0] bin_real;
      logic signed [23:0] bin_imag;
   } req_type;

   typedef struct packed {
      logic signed [14:0] level_centi_db;
      logic [9:0]         point_index;
      logic               last_point;
   } rsp_type;

   // Classified command that the front end queues for the engine.
   typedef struct packed {
      logic              is_load;
      logic [MAG_W-1:0]  abs_re;
      logic [MAG_W-1:0]  abs_im;
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SQ_RE,
      BK_SQ_IM,
      BK_ROOT,
      BK_SUM,
      BK_NORM,
      BK_LOG,
      BK_SCALE,
      BK_LEVEL,
      BK_EMIT
   } back_state_type;

   // Truncated log2 with LOG_FRAC fractional bits; used for constants only.
   function automatic longint log2_fixed_const(input longint unsigned x);
      int              e;
      longint unsigned m;
      longint unsigned frac;
      e = 63;
      frac = 0;
      while (e > 0 && ((x >> e) & 64'd1) == 64'd0) e--;
      if (e > 31) m = x >> (e - 31);
      else m = x << (31 - e);
      for (int b = LOG_FRAC - 1; b >= 0; b--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            frac = frac | (64'd1 << b);
            m = m >> 1;
         end
      end
      return longint'(e) * (64'sd1 << LOG_FRAC) + longint'(frac);
   endfunction

endpackage

// ----- hw/rtl/slmb_ram.sv -----
// ----------------------------------------------------------------------------
// slmb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slmb_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/slmb_front.sv -----
// ----------------------------------------------------------------------------
// slmb_front
// Accepts input beats, classifies them into load or read commands with the
// absolute values of the bin parts, and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module slmb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slmb_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output slmb_pkg::cmd_type cmd_data
);
   import slmb_pkg::*;

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cmd_new;

   // Classify the beat and take absolute values.
   always_comb begin
      cmd_new.is_load = (req_data.opcode == OP_LOAD);
      cmd_new.abs_re = req_data.bin_real[23] ? (~req_data.bin_real + 24'd1)
                                             : req_data.bin_real;
      cmd_new.abs_im = req_data.bin_imag[23] ? (~req_data.bin_imag + 24'd1)
                                             : req_data.bin_imag;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data = ent_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   property p_no_pop_empty;
      @(posedge clock) disable iff (reset) cmd_pop |-> cnt_ff != 2'd0;
   endproperty
   a_no_pop_empty: assert property (p_no_pop_empty)
      else $error("pop from empty queue");

   property p_cnt_bound;
      @(posedge clock) disable iff (reset) cnt_ff != 2'd3;
   endproperty
   a_cnt_bound: assert property (p_cnt_bound)
      else $error("queue count out of range");

   property p_cnt_track;
      @(posedge clock) disable iff (reset)
         (push && !cmd_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1;
   endproperty
   a_cnt_track: assert property (p_cnt_track)
      else $error("queue count lost a push");

endmodule

// ----- hw/rtl/slmb_back.sv -----
// ----------------------------------------------------------------------------
// slmb_back
// Engine: square root of loaded bins into the magnitude store, and window
// sum, fixed-point log and dB scaling for read requests.
// ----------------------------------------------------------------------------
module slmb_back #(
   parameter int unsigned MAX_FRAME_LOG2 = 12,
   parameter int unsigned DISPLAY_POINTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_clear,
   input  logic [3:0]        frame_log2,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  slmb_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slmb_pkg::rsp_type rsp_data
);
   import slmb_pkg::*;

   localparam int unsigned AW = MAX_FRAME_LOG2;
   localparam int unsigned CNT_W = AW + 1;
   localparam int unsigned SUM_W = MAG_W + AW;
   localparam int unsigned NRM_W = (SUM_W > 32) ? SUM_W : 32;
   localparam int unsigned E_W = $clog2(NRM_W);
   localparam int unsigned SQ_W = 2 * MAG_W + 2;

   // Window length for one frame size.
   function automatic int unsigned build_w_one(input int l);
      return (((1 << l) / DISPLAY_POINTS) == 0) ? 1 : (1 << l) / DISPLAY_POINTS;
   endfunction

   // Window length, point count and log2 of window per frame size.
   function automatic logic [15:0][31:0] build_w();
      logic [15:0][31:0] t;
      for (int l = 0; l < 16; l++) begin
         t[l] = (((1 << l) / DISPLAY_POINTS) == 0) ? 32'd1
                                                  : 32'((1 << l) / DISPLAY_POINTS);
      end
      return t;
   endfunction

   function automatic logic [15:0][31:0] build_p();
      logic [15:0][31:0] t;
      for (int l = 0; l < 16; l++) begin
         t[l] = ((1 << l) < DISPLAY_POINTS) ? 32'(1 << l) : 32'(DISPLAY_POINTS);
      end
      return t;
   endfunction

   function automatic logic [15:0][31:0] build_logw();
      logic [15:0][31:0] t;
      for (int l = 0; l < 16; l++) begin
         t[l] = 32'(log2_fixed_const(64'(build_w_one(l))));
      end
      return t;
   endfunction

   localparam logic [15:0][31:0] W_TAB = build_w();
   localparam logic [15:0][31:0] P_TAB = build_p();
   localparam logic [15:0][31:0] LOGW_TAB = build_logw();

   back_state_type st_ff, st_in;
   logic [CNT_W-1:0] ld_cnt_ff, ld_cnt_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0] base_ff, base_in;
   logic             ready_ff, ready_in;
   cmd_type          cmd_ff, cmd_in;
   logic [SQ_W-1:0]  rem_ff, rem_in;
   logic [SQ_W-1:0]  root_ff, root_in;
   logic [SQ_W-1:0]  bit_ff, bit_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic             pend_ff, pend_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [NRM_W-1:0] nrm_ff, nrm_in;
   logic [E_W-1:0]   e_ff, e_in;
   logic [31:0]      m_ff, m_in;
   logic [LOG_FRAC-1:0] frac_ff, frac_in;
   logic [4:0]       it_ff, it_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [14:0] lvl_ff, lvl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CNT_W-1:0] n_cur, half, mask, w_cur, p_cur;
   logic signed [31:0] logw;
   logic             out_free, last;
   logic [SQ_W-1:0]  trial, root_nx, rem_nx;
   logic [63:0]      prod;
   logic [32:0]      sq_t;
   logic signed [31:0] lg, dlog;
   logic signed [19:0] q;
   logic             wr_en, rd_en;
   logic [AW-1:0]    rd_addr;
   logic [MAG_W-1:0] rd_data;

   assign n_cur = CNT_W'(1) << frame_log2;
   assign half = n_cur >> 1;
   assign mask = n_cur - CNT_W'(1);
   assign w_cur = CNT_W'(W_TAB[frame_log2]);
   assign p_cur = CNT_W'(P_TAB[frame_log2]);
   assign logw = signed'(LOGW_TAB[frame_log2]);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last = (rd_cnt_ff + CNT_W'(1)) >= p_cur;

   // One root bit per cycle.
   always_comb begin
      trial = root_ff + bit_ff;
      if (rem_ff >= trial) begin
         rem_nx = rem_ff - trial;
         root_nx = (root_ff >> 1) + bit_ff;
      end else begin
         rem_nx = rem_ff;
         root_nx = root_ff >> 1;
      end
   end

   // One squaring step of the log.
   assign prod = 64'(m_ff) * 64'(m_ff);
   assign sq_t = prod[63:31];
   assign lg = signed'(32'(e_ff) << LOG_FRAC) + signed'(32'(frac_ff));
   assign dlog = lg - logw - (32'sd15 <<< LOG_FRAC);
   assign q = p_ff[63:44];

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.is_load) st_in = BK_SQ_RE;
               else if (ready_ff) st_in = BK_SUM;
            end
         end
         BK_SQ_RE: st_in = BK_SQ_IM;
         BK_SQ_IM: st_in = BK_ROOT;
         BK_ROOT: if (bit_ff[0]) st_in = BK_IDLE;
         BK_SUM: begin
            if (j_ff == w_cur && !pend_ff) begin
               st_in = (acc_ff == '0) ? BK_EMIT : BK_NORM;
            end
         end
         BK_NORM: if (nrm_ff[NRM_W-1]) st_in = BK_LOG;
         BK_LOG: if (it_ff == 5'd0) st_in = BK_SCALE;
         BK_SCALE: st_in = BK_LEVEL;
         BK_LEVEL: st_in = BK_EMIT;
         BK_EMIT: if (out_free) st_in = BK_IDLE;
         default: st_in = BK_IDLE;
      endcase
      if (cfg_clear) st_in = BK_IDLE;
   end

   // Datapath and counters.
   always_comb begin
      cmd_pop = 1'b0;
      ld_cnt_in = ld_cnt_ff;
      rd_cnt_in = rd_cnt_ff;
      base_in = base_ff;
      ready_in = ready_ff;
      cmd_in = cmd_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      j_in = j_ff;
      pend_in = 1'b0;
      acc_in = acc_ff;
      nrm_in = nrm_ff;
      e_in = e_ff;
      m_in = m_ff;
      frac_in = frac_ff;
      it_in = it_ff;
      p_in = p_ff;
      lvl_in = lvl_ff;
      wr_en = 1'b0;
      rd_en = 1'b0;
      rd_addr = AW'((base_ff + j_ff + half) & mask);
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (st_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in = cmd_data;
               j_in = '0;
               acc_in = '0;
            end
         end
         BK_SQ_RE: begin
            rem_in = SQ_W'(cmd_ff.abs_re) * SQ_W'(cmd_ff.abs_re);
         end
         BK_SQ_IM: begin
            rem_in = rem_ff + SQ_W'(cmd_ff.abs_im) * SQ_W'(cmd_ff.abs_im);
            root_in = '0;
            bit_in = SQ_W'(1) << (SQ_W - 2);
         end
         BK_ROOT: begin
            rem_in = rem_nx;
            root_in = root_nx;
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               // Store the magnitude and advance the frame.
               wr_en = 1'b1;
               if (ready_ff) begin
                  ready_in = 1'b0;
                  rd_cnt_in = '0;
                  base_in = '0;
               end
               if (ld_cnt_ff + CNT_W'(1) >= n_cur) begin
                  ld_cnt_in = '0;
                  ready_in = 1'b1;
                  rd_cnt_in = '0;
                  base_in = '0;
               end else begin
                  ld_cnt_in = ld_cnt_ff + CNT_W'(1);
               end
            end
         end
         BK_SUM: begin
            if (j_ff != w_cur) begin
               rd_en = 1'b1;
               j_in = j_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) acc_in = acc_ff + SUM_W'(rd_data);
            if (j_ff == w_cur && !pend_ff) begin
               nrm_in = NRM_W'(acc_ff) << (NRM_W - SUM_W);
               e_in = E_W'(SUM_W - 1);
               lvl_in = ZERO_LEVEL;
            end
         end
         BK_NORM: begin
            if (!nrm_ff[NRM_W-1]) begin
               nrm_in = nrm_ff << 1;
               e_in = e_ff - E_W'(1);
            end else begin
               m_in = nrm_ff[NRM_W-1 -: 32];
               frac_in = '0;
               it_in = 5'(LOG_FRAC - 1);
            end
         end
         BK_LOG: begin
            m_in = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            frac_in = {frac_ff[LOG_FRAC-2:0], sq_t[32]};
            it_in = it_ff - 5'd1;
         end
         BK_SCALE: begin
            p_in = 64'(dlog) * 64'(DB_SCALE);
         end
         BK_LEVEL: begin
            if (q < LVL_MIN) lvl_in = 15'(LVL_MIN);
            else if (q > LVL_MAX) lvl_in = 15'(LVL_MAX);
            else lvl_in = 15'(q);
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.level_centi_db = lvl_ff;
               rsp_in.point_index = 10'(rd_cnt_ff);
               rsp_in.last_point = last;
               if (last) begin
                  ready_in = 1'b0;
                  rd_cnt_in = '0;
                  base_in = '0;
               end else begin
                  rd_cnt_in = rd_cnt_ff + CNT_W'(1);
                  base_in = base_ff + w_cur;
               end
            end
         end
         default: begin
         end
      endcase
      if (cfg_clear) begin
         ld_cnt_in = '0;
         rd_cnt_in = '0;
         base_in = '0;
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         ld_cnt_ff <= '0;
         rd_cnt_ff <= '0;
         base_ff <= '0;
         ready_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ld_cnt_ff <= ld_cnt_in;
         rd_cnt_ff <= rd_cnt_in;
         base_ff <= base_in;
         ready_ff <= ready_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      j_ff <= j_in;
      acc_ff <= acc_in;
      nrm_ff <= nrm_in;
      e_ff <= e_in;
      m_ff <= m_in;
      frac_ff <= frac_in;
      it_ff <= it_in;
      p_ff <= p_in;
      lvl_ff <= lvl_in;
      rsp_ff <= rsp_in;
   end

   slmb_ram #(
      .WIDTH (MAG_W),
      .DEPTH (1 << AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(ld_cnt_ff)),
      .wr_data (root_nx[MAG_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   property p_ld_bound;
      @(posedge clock) disable iff (reset) ld_cnt_ff < n_cur;
   endproperty
   a_ld_bound: assert property (p_ld_bound)
      else $error("load count past frame size");

   property p_idle_counts;
      @(posedge clock) disable iff (reset)
         !ready_ff |-> (rd_cnt_ff == '0 && base_ff == '0);
   endproperty
   a_idle_counts: assert property (p_idle_counts)
      else $error("read position kept without a ready frame");

   property p_rd_bound;
      @(posedge clock) disable iff (reset) ready_ff |-> rd_cnt_ff < p_cur;
   endproperty
   a_rd_bound: assert property (p_rd_bound)
      else $error("read count past point count");

endmodule

// ----- hw/rtl/spectrum_log_magnitude_binning.sv -----
// ----------------------------------------------------------------------------
// spectrum_log_magnitude_binning
// Stores FFT bin magnitudes of a frame and serves half-swapped, window-
// averaged display points as log levels in hundredths of a dB.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one beat per bin load (opcode 0) or per display
// point request (opcode 1). A load returns nothing; a request returns one
// rsp beat once a full frame of 2^frame_size_log2 bins is in, and is
// dropped otherwise. The APB register at address 0 sets frame_size_log2
// and restarts the frame; write it only while the block is idle.
// In the engine, a load takes the command, squares the real and imaginary
// parts and runs 25 square-root bit steps. A request takes the command,
// reads the store once per window bin, normalizes the sum, runs 24
// squaring steps of the log, then scales and clamps the level and emits
// it as one rsp beat; the engine handles
// one beat at a time. A two-entry queue in front lets req beats be taken
// while the engine works, and the output register lets the engine go on
// while a finished rsp beat waits under stall. Reset clears the counters
// and sets frame_size_log2 to 10; the magnitude store is not cleared.
// ----------------------------------------------------------------------------
module spectrum_log_magnitude_binning #(
   parameter int unsigned MAX_FRAME_LOG2 = 12,
   parameter int unsigned DISPLAY_POINTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  slmb_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output slmb_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [slmb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import slmb_pkg::*;

   logic [3:0]  frame_log2_ff, frame_log2_in;
   logic [3:0]  frame_log2_use;
   logic        csr_wr, csr_hit;
   logic        cmd_valid, cmd_pop;
   cmd_type     cmd_data;

   // Register access.
   assign pready = 1'b1;
   assign csr_hit = (paddr[2] == CSR_IDX_FRAME_LOG2);
   assign csr_wr = psel && penable && pwrite && csr_hit;
   assign prdata = csr_hit ? 32'(frame_log2_ff) : 32'd0;
   assign frame_log2_in = csr_wr ? pwdata[3:0] : frame_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_log2_ff <= FRAME_LOG2_RESET;
      end else begin
         frame_log2_ff <= frame_log2_in;
      end
   end

   // Clamp frame size to the supported range.
   always_comb begin
      if (frame_log2_ff < FRAME_LOG2_MIN) frame_log2_use = FRAME_LOG2_MIN;
      else if (32'(frame_log2_ff) > MAX_FRAME_LOG2) frame_log2_use = 4'(MAX_FRAME_LOG2);
      else frame_log2_use = frame_log2_ff;
   end

   slmb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   slmb_back #(
      .MAX_FRAME_LOG2 (MAX_FRAME_LOG2),
      .DISPLAY_POINTS (DISPLAY_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_clear  (csr_wr),
      .frame_log2 (frame_log2_use),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_data   (cmd_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
